### src/ght_pkg.sv
// Shared types and codes for the generational handle table.
// Holds the fixed field widths, the action codes and the item/result structs.
// No dependencies.
package ght_pkg;

  // Field widths of the stream payload
  localparam int ACTION_W   = 2;
  localparam int HSLOT_W    = 10;
  localparam int HGEN_W     = 16;
  localparam int RECORD_W   = 64;
  localparam int LIVE_CNT_W = 11;

  // Packed stream widths; the tdata widths are padded to whole bytes
  localparam int IN_TUSER_W  = ACTION_W;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 104;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HSLOT_W-1:0]  handle_slot;
    logic [HGEN_W-1:0]   handle_generation;
    logic [RECORD_W-1:0] record_data;
  } ght_item_t;

  typedef struct packed {
    logic                  ok;
    logic [HSLOT_W-1:0]    slot_out;
    logic [HGEN_W-1:0]     generation_out;
    logic [RECORD_W-1:0]   data_out;
    logic [LIVE_CNT_W-1:0] live_count;
  } ght_result_t;

endpackage

### src/ght_slot_mem.sv
// Slot memory of the handle table: live bit, generation and record per slot.
// One write port, one registered read port; a fill count masks never-written
// entries so that they read as a dead slot of generation zero. Uses no package.
module ght_slot_mem #(
  parameter int SLOTS  = 1024,
  parameter int DATA_W = 64,
  parameter int GEN_W  = 16,
  localparam int AW    = $clog2(SLOTS),
  localparam int CW    = $clog2(SLOTS + 1),
  localparam int WW    = DATA_W + GEN_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic              rd_live,
  output logic [GEN_W-1:0]  rd_gen,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic              wr_live,
  input  logic [GEN_W-1:0]  wr_gen,
  input  logic [DATA_W-1:0] wr_data
);

  logic [WW-1:0] mem [SLOTS];
  logic [WW-1:0] rd_word_r;
  logic          rd_fresh_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_live, wr_gen, wr_data};
    end
    if (rd_en) begin
      rd_word_r  <= mem[rd_addr];
      rd_fresh_r <= (CW'(rd_addr) >= fill_r);
    end
  end

  // fill count: one past the highest slot ever written
  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (CW'(wr_addr) >= fill_r)) begin
      fill_nxt = CW'(wr_addr) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_live = !rd_fresh_r && rd_word_r[WW-1];
  assign rd_gen  = rd_fresh_r ? '0 : rd_word_r[WW-2:DATA_W];
  assign rd_data = rd_word_r[DATA_W-1:0];

endmodule

### src/ght_free_stack.sv
// LIFO of freed slot numbers with its depth counter.
// Pop data is registered and comes out in the cycle after the pop; flush empties it at once.
// Uses no package.
module ght_free_stack #(
  parameter int SLOTS = 1024,
  localparam int AW   = $clog2(SLOTS),
  localparam int CW   = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop,
  output logic [AW-1:0] pop_data,
  input  logic          push,
  input  logic [AW-1:0] push_data,
  input  logic          flush,
  output logic          empty,
  output logic          full
);

  logic [AW-1:0] mem [SLOTS];
  logic [AW-1:0] pop_data_r;
  logic [CW-1:0] depth_r;
  logic [CW-1:0] depth_nxt;

  assign empty    = (depth_r == '0);
  assign full     = (depth_r == CW'(SLOTS));
  assign pop_data = pop_data_r;

  // stack storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[AW'(depth_r)] <= push_data;
    end
    if (pop && !empty) begin
      pop_data_r <= mem[AW'(depth_r - 1'b1)];
    end
  end

  // depth pointer
  always_comb begin
    depth_nxt = depth_r;
    if (flush) begin
      depth_nxt = '0;
    end else if (pop && !empty) begin
      depth_nxt = depth_r - 1'b1;
    end else if (push && !full) begin
      depth_nxt = depth_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

endmodule

### src/ght_ctrl.sv
// Sequencer of the handle table: read-modify-write of the slot memory per item,
// free stack control, high-water mark, live count and the clear walk.
// Depends on ght_pkg.
module ght_ctrl import ght_pkg::*; #(
  parameter int SLOTS  = 1024,
  parameter int DATA_W = 64,
  parameter int GEN_W  = 16,
  localparam int AW    = $clog2(SLOTS),
  localparam int CW    = $clog2(SLOTS + 1),
  localparam int MW    = (GEN_W > HGEN_W) ? GEN_W : HGEN_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ght_item_t         item,
  output logic              res_valid,
  input  logic              res_ready,
  output ght_result_t       res,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  logic              mem_rd_live,
  input  logic [GEN_W-1:0]  mem_rd_gen,
  input  logic [DATA_W-1:0] mem_rd_data,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output logic              mem_wr_live,
  output logic [GEN_W-1:0]  mem_wr_gen,
  output logic [DATA_W-1:0] mem_wr_data,
  output logic              fs_pop,
  input  logic [AW-1:0]     fs_pop_data,
  output logic              fs_push,
  output logic [AW-1:0]     fs_push_data,
  output logic              fs_flush,
  input  logic              fs_empty,
  input  logic              fs_full
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       hw_r, hw_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic [CW-1:0]       clr_idx_r, clr_idx_nxt;
  logic                clr_wr_r, clr_wr_nxt;
  // item payload
  logic [ACTION_W-1:0] op_r, op_nxt;
  logic [HGEN_W-1:0]   hgen_r, hgen_nxt;
  logic [DATA_W-1:0]   data_r, data_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic                oob_r, oob_nxt;
  logic                fail_r, fail_nxt;
  logic                from_stack_r, from_stack_nxt;

  logic                hit;
  logic [CW-1:0]       live_after;

  assign in_ready = (state_r == S_IDLE);
  assign hit      = !oob_r && mem_rd_live && (MW'(hgen_r) == MW'(mem_rd_gen));

  always_comb begin
    state_nxt      = state_r;
    hw_nxt         = hw_r;
    live_nxt       = live_r;
    clr_idx_nxt    = clr_idx_r;
    clr_wr_nxt     = clr_wr_r;
    op_nxt         = op_r;
    hgen_nxt       = hgen_r;
    data_nxt       = data_r;
    slot_nxt       = slot_r;
    oob_nxt        = oob_r;
    fail_nxt       = fail_r;
    from_stack_nxt = from_stack_r;
    live_after     = live_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = slot_r;
    mem_wr_live    = 1'b0;
    mem_wr_gen     = mem_rd_gen;
    mem_wr_data    = mem_rd_data;
    fs_pop         = 1'b0;
    fs_push        = 1'b0;
    fs_push_data   = slot_r;
    fs_flush       = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    unique case (state_r)
      // take an item and start its memory read, free stack pop or clear walk
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = item.action;
          hgen_nxt       = item.handle_generation;
          data_nxt       = DATA_W'(item.record_data);
          oob_nxt        = 1'b0;
          fail_nxt       = 1'b0;
          from_stack_nxt = 1'b0;
          case (item.action) inside
            ACT_ADD: begin
              if (!fs_empty) begin
                fs_pop         = 1'b1;
                from_stack_nxt = 1'b1;
                state_nxt      = S_POP;
              end else if (hw_r < CW'(SLOTS)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(hw_r);
                slot_nxt    = AW'(hw_r);
                state_nxt   = S_EXEC;
              end else begin
                fail_nxt  = 1'b1;
                state_nxt = S_EXEC;
              end
            end
            ACT_REMOVE, ACT_LOOKUP: begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = AW'(item.handle_slot);
              slot_nxt    = AW'(item.handle_slot);
              oob_nxt     = (32'(item.handle_slot) >= 32'(SLOTS));
              state_nxt   = S_EXEC;
            end
            default: begin
              // clear all
              clr_idx_nxt = '0;
              clr_wr_nxt  = 1'b0;
              state_nxt   = S_CLR;
            end
          endcase
        end
      end

      // recycled slot number is out; read that slot
      S_POP: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = fs_pop_data;
        slot_nxt    = fs_pop_data;
        state_nxt   = S_EXEC;
      end

      // clear walk: read slot i while writing back slot i-1
      S_CLR: begin
        if (clr_wr_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(clr_idx_r - 1'b1);
          mem_wr_live = 1'b0;
          mem_wr_gen  = mem_rd_live ? mem_rd_gen + 1'b1 : mem_rd_gen;
        end
        if (clr_idx_r < hw_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(clr_idx_r);
          clr_idx_nxt = clr_idx_r + 1'b1;
          clr_wr_nxt  = 1'b1;
        end else begin
          clr_wr_nxt = 1'b0;
          if (!clr_wr_r) begin
            state_nxt = S_EXEC;
          end
        end
      end

      // finish the item: write back and present the result
      S_EXEC: begin
        res_valid = 1'b1;
        case (op_r) inside
          ACT_ADD: begin
            if (!fail_r) begin
              live_after         = live_r + 1'b1;
              res.ok             = 1'b1;
              res.slot_out       = HSLOT_W'(slot_r);
              res.generation_out = HGEN_W'(mem_rd_gen);
            end
          end
          ACT_REMOVE: begin
            if (hit) begin
              live_after = (live_r != '0) ? live_r - 1'b1 : live_r;
              res.ok     = 1'b1;
            end
          end
          ACT_LOOKUP: begin
            if (hit) begin
              res.ok       = 1'b1;
              res.data_out = RECORD_W'(mem_rd_data);
            end
          end
          default: begin
            live_after = '0;
            res.ok     = 1'b1;
          end
        endcase
        res.live_count = LIVE_CNT_W'(live_after);

        if (res_ready) begin
          state_nxt = S_IDLE;
          live_nxt  = live_after;
          case (op_r) inside
            ACT_ADD: begin
              if (!fail_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_live = 1'b1;
                mem_wr_data = data_r;
                if (!from_stack_r) begin
                  hw_nxt = hw_r + 1'b1;
                end
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                mem_wr_en   = 1'b1;
                mem_wr_live = 1'b0;
                mem_wr_gen  = mem_rd_gen + 1'b1;
                fs_push     = !fs_full;
              end
            end
            ACT_LOOKUP: begin
            end
            default: begin
              fs_flush = 1'b1;
              hw_nxt   = '0;
            end
          endcase
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      hw_r      <= '0;
      live_r    <= '0;
      clr_idx_r <= '0;
      clr_wr_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hw_r      <= hw_nxt;
      live_r    <= live_nxt;
      clr_idx_r <= clr_idx_nxt;
      clr_wr_r  <= clr_wr_nxt;
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hgen_r       <= hgen_nxt;
    data_r       <= data_nxt;
    slot_r       <= slot_nxt;
    oob_r        <= oob_nxt;
    fail_r       <= fail_nxt;
    from_stack_r <= from_stack_nxt;
  end

  // live slots never outnumber the slots handed out from the fresh range
  a_live_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= hw_r)
    else $error("live count above high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= CW'(SLOTS))
    else $error("high-water mark beyond table");

  a_fs_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fs_pop && fs_push))
    else $error("free stack push and pop together");

  a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (item.action == ACT_CLEAR)) |=> (state_r == S_CLR))
    else $error("clear did not start its walk");

  a_clr_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!res_valid && !in_ready))
    else $error("result or accept during clear walk");

endmodule

### src/generational_handle_table.sv
// Generational handle table.
// Input channel in_*: one transfer is one request (add, remove, lookup, clear),
// the action code in in_tuser, the handle and record word in in_tdata. Result
// channel out_*: exactly one result transfer per request, in request order.
// Handles are {slot, generation}; a handle is live while its slot is live and
// the generations match. Add reuses the most recently freed slot, else the next
// fresh slot, and reports ok=0 when all slots are taken.
// Steps: remove, lookup and add of a fresh slot pass an accept state that reads
// the slot memory, then a write-back state; add of a recycled slot first pops the
// free stack, then reads the slot, then writes back. Clear walks every slot below
// the high-water mark, one per cycle. The slot memory has a registered read port.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the block in its write-back cycle.
// Reset empties the table and zeroes all generations at once; no clearing pass
// is needed, as slots above the fill mark read as dead with generation zero.
// Depends on ght_pkg, ght_slot_mem, ght_free_stack and ght_ctrl.
module generational_handle_table import ght_pkg::*; #(
  parameter int SLOTS  = 1024,
  parameter int DATA_W = 64,
  parameter int GEN_W  = 16,
  localparam int AW    = $clog2(SLOTS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // handle_slot[9:0], handle_generation[25:10], record_data[89:26], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // ok[0], slot_out[10:1], generation_out[26:11], data_out[90:27],
  // live_count[101:91], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ght_item_t         item;
  ght_result_t       res;
  ght_result_t       out_res_r;
  logic              out_tvalid_r;
  logic              res_valid;
  logic              res_ready;

  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic              mem_rd_live;
  logic [GEN_W-1:0]  mem_rd_gen;
  logic [DATA_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic              mem_wr_live;
  logic [GEN_W-1:0]  mem_wr_gen;
  logic [DATA_W-1:0] mem_wr_data;
  logic              fs_pop;
  logic [AW-1:0]     fs_pop_data;
  logic              fs_push;
  logic [AW-1:0]     fs_push_data;
  logic              fs_flush;
  logic              fs_empty;
  logic              fs_full;

  // unpack the request
  assign item.action            = in_tuser;
  assign item.handle_slot       = in_tdata[9:0];
  assign item.handle_generation = in_tdata[25:10];
  assign item.record_data       = in_tdata[89:26];

  ght_slot_mem #(
    .SLOTS  (SLOTS),
    .DATA_W (DATA_W),
    .GEN_W  (GEN_W)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_live (mem_rd_live),
    .rd_gen  (mem_rd_gen),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_live (mem_wr_live),
    .wr_gen  (mem_wr_gen),
    .wr_data (mem_wr_data)
  );

  ght_free_stack #(
    .SLOTS (SLOTS)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (fs_pop),
    .pop_data  (fs_pop_data),
    .push      (fs_push),
    .push_data (fs_push_data),
    .flush     (fs_flush),
    .empty     (fs_empty),
    .full      (fs_full)
  );

  ght_ctrl #(
    .SLOTS  (SLOTS),
    .DATA_W (DATA_W),
    .GEN_W  (GEN_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .item         (item),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_live  (mem_rd_live),
    .mem_rd_gen   (mem_rd_gen),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_live  (mem_wr_live),
    .mem_wr_gen   (mem_wr_gen),
    .mem_wr_data  (mem_wr_data),
    .fs_pop       (fs_pop),
    .fs_pop_data  (fs_pop_data),
    .fs_push      (fs_push),
    .fs_push_data (fs_push_data),
    .fs_flush     (fs_flush),
    .fs_empty     (fs_empty),
    .fs_full      (fs_full)
  );

  // output register: loads when empty or draining this cycle
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_res_r.live_count, out_res_r.data_out,
                       out_res_r.generation_out, out_res_r.slot_out, out_res_r.ok};

endmodule
